// ===== sv/fqc_pkg.sv =====
// Shared constants and types for the Q15 circular-buffer FIR filter.
package fqc_pkg;

    localparam int TAPS   = 21;
    localparam int DATA_W = 16;
    localparam int CIDX_W = 5;
    localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W = 2 * DATA_W;

    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // Controls for the multiply-accumulate stages
    typedef struct packed {
        logic clear;
        logic vld;
        logic sval;
    } mac_ctl_t;

endpackage

// ===== sv/fqc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fqc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 21,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fqc_mac.sv =====
// Multiply and accumulate stages: one registered Q15 product, one 16-bit accumulator.
module fqc_mac
    import fqc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] sample,
    input  logic signed [DATA_W-1:0] coeff,
    output logic [DATA_W-1:0]        acc,
    output logic                     busy
);

    logic signed [DATA_W-1:0] sample_eff;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic [DATA_W-1:0]        acc_reg;
    logic [DATA_W-1:0]        acc_next;

    // A slot never written since reset reads as zero
    assign sample_eff = ctl.sval ? sample : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sample_eff * coeff;
        acc_reg  <= acc_next;
    end

    // Only the low 16 bits of the sum survive: take bits 30..15 of each product
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + prod_reg[PROD_W-2:DATA_W-1];
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

// ===== sv/fir_filter_q15_circular_unit.sv =====
// Q15 FIR filter top: delay line and coefficients in RAM, one tap per cycle.
// Load word: no result; the next word can be accepted the cycle after.
// Sample word: TAPS reads, then read, multiply, accumulate and output register in
// order; the next sample is accepted once the result is loaded for output.
// The single shared multiplier and the one read port per RAM set the tap rate.
// rst_n (async, active low) zeroes the delay line through per-slot valid bits
// and the write position; coefficients stay undefined until loaded.
module fir_filter_q15_circular_unit
    import fqc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [CIDX_W-1:0]        coeff_index,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] filtered_sample
);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    wr_pos_reg, wr_pos_next;
    logic [IDX_W-1:0]    s_addr_reg, s_addr_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [TAPS-1:0]     valid_reg;
    logic                p1_vld_reg;
    logic                p1_sval_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg;

    logic                accept;
    logic                accept_sample;
    logic                coeff_we;
    logic                issue;
    logic [IDX_W-1:0]    pos_inc;
    logic [DATA_W-1:0]   s_rdata;
    logic [DATA_W-1:0]   c_rdata;
    logic [DATA_W-1:0]   acc;
    logic                mac_busy;
    logic                out_load;
    mac_ctl_t            mac_ctl;

    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign accept_sample = accept && (command == CMD_SAMPLE);
    assign coeff_we      = accept && (command == CMD_LOAD) && (32'(coeff_index) < TAPS);
    assign issue         = (state_reg == S_RUN);
    assign pos_inc       = (32'(wr_pos_reg) == TAPS - 1) ? '0 : wr_pos_reg + 1'b1;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    fqc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TAPS)
    ) u_sample_ram (
        .clk   (clk),
        .we    (accept_sample),
        .waddr (wr_pos_reg),
        .wdata (value),
        .raddr (s_addr_reg),
        .rdata (s_rdata)
    );

    fqc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TAPS)
    ) u_coeff_ram (
        .clk   (clk),
        .we    (coeff_we),
        .waddr (IDX_W'(coeff_index)),
        .wdata (value),
        .raddr (cnt_reg),
        .rdata (c_rdata)
    );

    assign mac_ctl.clear = accept_sample;
    assign mac_ctl.vld   = p1_vld_reg;
    assign mac_ctl.sval  = p1_sval_reg;

    fqc_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .sample (s_rdata),
        .coeff  (c_rdata),
        .acc    (acc),
        .busy   (mac_busy)
    );

    always_comb
    begin
        state_next  = state_reg;
        wr_pos_next = wr_pos_reg;
        s_addr_next = s_addr_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_sample)
                begin
                    // Oldest sample sits just past the newest one
                    wr_pos_next = pos_inc;
                    s_addr_next = pos_inc;
                    cnt_next    = '0;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                s_addr_next = (32'(s_addr_reg) == TAPS - 1) ? '0 : s_addr_reg + 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (32'(cnt_reg) == TAPS - 1)
                begin
                    cnt_next   = '0;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                // Wait for the last tap to drain into the accumulator
                if (!p1_vld_reg && !mac_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_pos_reg    <= '0;
            s_addr_reg    <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            p1_vld_reg    <= 1'b0;
            p1_sval_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_pos_reg  <= wr_pos_next;
            s_addr_reg  <= s_addr_next;
            cnt_reg     <= cnt_next;
            p1_vld_reg  <= issue;
            p1_sval_reg <= valid_reg[s_addr_reg];
            if (accept_sample)
            begin
                valid_reg[wr_pos_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= acc;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_data_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wr_pos_reg) < TAPS)
        else $error("write position out of range");

    a_read_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        p1_vld_reg |-> $past(state_reg == S_RUN))
        else $error("tap read outside of run phase");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word not from done state");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (!p1_vld_reg && !mac_busy))
        else $error("result taken before accumulation finished");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the Q15 circular-buffer FIR filter.
`timescale 1ns / 1ps

module testbench
    import fqc_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_WORDS = 1100;
    localparam int IDLE_PCT     = 36;

    typedef struct {
        bit                       drain;
        cmd_t                     cmd;
        logic [CIDX_W-1:0]        idx;
        logic signed [DATA_W-1:0] val;
    } fir_word_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     command = 1'b0;
    logic [CIDX_W-1:0]        coeff_index = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] filtered_sample;

    // filter state as seen from the ports
    logic signed [DATA_W-1:0] history [TAPS] = '{default: '0};
    logic signed [DATA_W-1:0] coeffs [TAPS] = '{default: '0};
    int                       head = 0;

    fir_word_t                word_q [$];
    logic signed [DATA_W-1:0] expected_q [$];
    fir_word_t                next_word;
    logic signed [DATA_W-1:0] oldest;

    int tick_count = 0;
    int mismatch_count = 0;
    int samples_sent = 0;
    int loads_sent = 0;
    int loads_ignored = 0;
    int outputs_checked = 0;

    fir_filter_q15_circular_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .coeff_index     (coeff_index),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", tick_count, msg);
        mismatch_count++;
    endtask

    function automatic void load_coefficient(input logic [CIDX_W-1:0] idx,
                                             input logic signed [DATA_W-1:0] val);
        if (idx < TAPS)
            coeffs[idx] = val;
        else
            loads_ignored++;
    endfunction

    // Write the sample, advance the head, then sum oldest-to-newest against coeffs 0..TAPS-1.
    function automatic logic signed [DATA_W-1:0] filter_step(
        input logic signed [DATA_W-1:0] smp);
        int                       pos;
        logic signed [PROD_W-1:0] prod;
        logic [PROD_W-1:0]        doubled;
        logic [31:0]              acc;
        history[head] = smp;
        head = (head + 1) % TAPS;
        pos = head;
        acc = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            prod = history[pos] * coeffs[i];
            doubled = prod << 1;
            acc = acc + {{16{doubled[31]}}, doubled[31:16]};
            pos = (pos + 1) % TAPS;
        end
        return acc[DATA_W-1:0];
    endfunction

    function automatic void push_word(input cmd_t cmd, input int idx, input int val);
        fir_word_t w;
        w.drain = 1'b0;
        w.cmd = cmd;
        w.idx = idx[CIDX_W-1:0];
        w.val = val[DATA_W-1:0];
        word_q.push_back(w);
    endfunction

    function automatic void push_drain();
        fir_word_t w;
        w.drain = 1'b1;
        w.cmd = CMD_LOAD;
        w.idx = '0;
        w.val = '0;
        word_q.push_back(w);
    endfunction

    // Driver: predict on acceptance, then present the next word or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (command == CMD_SAMPLE)
                begin
                    expected_q.push_back(filter_step(value));
                    samples_sent++;
                end
                else
                begin
                    load_coefficient(coeff_index, value);
                    loads_sent++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (word_q.size() > 0 && word_q[0].drain)
                begin
                    // hold off until every pending output has drained
                    if (expected_q.size() == 0)
                        void'(word_q.pop_front());
                    in_valid <= 1'b0;
                end
                else if (word_q.size() > 0 &&
                         ((samples_sent + loads_sent >= 300 &&
                           samples_sent + loads_sent < 600) ||
                          $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_word = word_q.pop_front();
                    in_valid <= 1'b1;
                    command <= next_word.cmd;
                    coeff_index <= next_word.idx;
                    value <= next_word.val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each output word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("output %0d with nothing pending",
                                              filtered_sample));
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    if (filtered_sample !== oldest)
                        report_mismatch($sformatf("filtered_sample %0d, predicted %0d",
                                                  filtered_sample, oldest));
                end
                outputs_checked++;
            end
            out_ready <= (outputs_checked >= 350 && outputs_checked < 600) ||
                         ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        tick_count <= tick_count + 1;
        if (tick_count == LIMIT_CYCLES)
        begin
            $display("tb: gave up after %0d cycles, %0d outputs still pending",
                     tick_count, expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int r;
        int v;
        // every tap gets a coefficient before the first sample
        for (int i = 0; i < TAPS; i++)
        begin
            case (i)
                5:       v = 0;
                6:       v = 1;
                7:       v = -1;
                default: v = (i % 3 == 1) ? 32767 : -32768;
            endcase
            push_word(CMD_LOAD, i, v);
        end
        // loads past the last tap must change nothing
        push_word(CMD_LOAD, TAPS, 12345);
        push_word(CMD_LOAD, 31, -1);
        // extreme samples, repeated minimum drives the sum past 16 bits
        push_word(CMD_SAMPLE, 31, -32768);
        push_word(CMD_SAMPLE, 0, -32768);
        push_word(CMD_SAMPLE, 0, 32767);
        push_word(CMD_SAMPLE, 0, -1);
        push_word(CMD_SAMPLE, 0, 1);
        push_drain();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 650)
                push_drain();
            r = $urandom_range(0, 99);
            if (r < 10)
                v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            else
                v = int'(16'($urandom));
            if (r >= 10 && r < 28)
                push_word(CMD_LOAD, $urandom_range(0, 31), v);
            else
                push_word(CMD_SAMPLE, $urandom_range(0, 31), v);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // sample the queues away from the clock edge so every update has settled
        while (word_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);

        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d outputs never arrived", expected_q.size()));

        $display("tb: filtered %0d samples, applied %0d coefficient loads (%0d past the last tap)",
                 samples_sent, loads_sent, loads_ignored);
        $display("tb: checked %0d outputs, %0d mismatches", outputs_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fqc_pkg.sv
sv/fqc_ram.sv
sv/fqc_mac.sv
sv/fir_filter_q15_circular_unit.sv
test/testbench.sv
